@@ rtl/csf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants for the column scaling block
// Widths, the column count and the column record passed to the back end.
// ----------------------------------------------------------------------------
package csf_pkg;
	localparam int MaxCols = 4096;
	localparam int ColW = 12;
	localparam logic [63:0] TolReset = 64'd1;

	typedef struct packed {
		logic [ColW-1:0] col;
		logic [63:0]     sum;
		logic            sat;
		logic [63:0]     tol;
	} col_rec_t;
endpackage

@@ rtl/csf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_front: sum-of-squares accumulator
// Squares each value, adds with saturation, emits a column record at column end.
// Two stages: square, then accumulate.
// ----------------------------------------------------------------------------
module csf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [31:0]    value,
	input  logic                  has_value,
	input  logic                  last_in_column,
	input  logic [63:0]           tol,
	output logic                  in_stall,
	output logic                  rec_valid,
	output csf_pkg::col_rec_t     rec,
	input  logic                  rec_stall
);
	logic        v_s1, has_s1, last_s1;
	logic [63:0] sq_s1;
	logic [63:0] sum_q;
	logic        sat_q;
	logic [csf_pkg::ColW-1:0] col_q;
	logic [31:0] mag;
	logic [64:0] ns;
	logic        adv;

	// both stages block only when a record waits downstream
	assign adv = !(rec_valid && rec_stall);
	assign in_stall = !adv;
	assign mag = value[31] ? (~value + 32'd1) : value;
	assign ns = {1'b0, sum_q} + {1'b0, (has_s1 ? sq_s1 : 64'd0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sum_q <= '0;
			sat_q <= 1'b0;
			col_q <= '0;
			rec_valid <= 1'b0;
			rec <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			rec_valid <= v_s1 && last_s1;
			if (v_s1) begin
				if (last_s1) begin
					rec.col <= col_q;
					rec.sum <= ns[64] ? '1 : ns[63:0];
					rec.sat <= sat_q | ns[64];
					rec.tol <= tol;
					sum_q <= '0;
					sat_q <= 1'b0;
					col_q <= (32'(col_q) + 32'd1 >= csf_pkg::MaxCols) ? '0 : col_q + 1'b1;
				end else begin
					sum_q <= ns[64] ? '1 : ns[63:0];
					sat_q <= sat_q | ns[64];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1 <= 64'(mag) * 64'(mag);
			has_s1 <= has_value;
			last_s1 <= last_in_column;
		end
	end
endmodule

@@ rtl/csf_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_fifo: four-entry record queue
// Decouples the accumulator from the reciprocal square root unit.
// ----------------------------------------------------------------------------
module csf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	input  csf_pkg::col_rec_t wr_data,
	output logic              wr_stall,
	output logic              rd_valid,
	output csf_pkg::col_rec_t rd_data,
	input  logic              rd_take
);
	csf_pkg::col_rec_t mem [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data = mem[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule

@@ rtl/csf_rsqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_rsqrt: bit-serial reciprocal square root
// Finds the largest q with q*q*S <= 2^64 bit by bit, one record at a time, and
// holds it in an output register (0 below tolerance, all ones if S <= 1).
// ----------------------------------------------------------------------------
module csf_rsqrt (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	input  csf_pkg::col_rec_t     rec,
	output logic                  rec_take,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0]           column_index,
	output logic [31:0]           scale,
	output logic                  below_tolerance,
	output logic                  saturated
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SQ   = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t      st_q;
	logic [4:0]  bit_q;
	logic [31:0] q_q, t;
	logic [63:0] tt_q;
	logic [63:0] s_q;
	logic [11:0] col_q;
	logic        sat_q;
	logic [1:0]  ph_q;
	logic [127:0] acc_q;
	logic [63:0] pp;
	logic        out_free, below, hit, emit;

	assign t = q_q | (32'd1 << bit_q);
	assign below = rec.sum < rec.tol;
	assign out_free = !out_valid || !out_stall;
	assign rec_take = (st_q == ST_IDLE) && rec_valid && out_free;
	// trial bit kept when t*t*S <= 2^64
	assign hit = (acc_q[127:64] == 64'd0) ||
			(acc_q[127:64] == 64'd1 && acc_q[63:0] == 64'd0);
	assign emit = rec_take ? (below || rec.sum <= 64'd1) :
			((st_q == ST_DONE) && (bit_q == 5'd0) && out_free);

	// 64x64 product built from four 32x32 partial products, one per cycle
	always_comb begin
		case (ph_q)
			2'd0: pp = 64'(tt_q[31:0]) * 64'(s_q[31:0]);
			2'd1: pp = 64'(tt_q[31:0]) * 64'(s_q[63:32]);
			2'd2: pp = 64'(tt_q[63:32]) * 64'(s_q[31:0]);
			default: pp = 64'(tt_q[63:32]) * 64'(s_q[63:32]);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			bit_q <= '0;
			q_q <= '0;
			tt_q <= '0;
			s_q <= '0;
			col_q <= '0;
			sat_q <= 1'b0;
			ph_q <= '0;
			acc_q <= '0;
			column_index <= '0;
			scale <= '0;
			below_tolerance <= 1'b0;
			saturated <= 1'b0;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (rec_take) begin
						col_q <= rec.col;
						s_q <= rec.sum;
						sat_q <= rec.sat;
						q_q <= '0;
						bit_q <= 5'd31;
						if (below || rec.sum <= 64'd1) begin
							column_index <= rec.col;
							below_tolerance <= below;
							scale <= below ? 32'd0 : 32'hFFFF_FFFF;
							saturated <= rec.sat | !below;
						end else begin
							st_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					tt_q <= 64'(t) * 64'(t);
					acc_q <= '0;
					ph_q <= 2'd0;
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					case (ph_q)
						2'd0: acc_q <= acc_q + 128'(pp);
						2'd3: acc_q <= acc_q + {pp, 64'd0};
						default: acc_q <= acc_q + {32'd0, pp, 32'd0};
					endcase
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (hit)
						q_q <= t;
					if (bit_q == 5'd0) begin
						if (out_free) begin
							column_index <= col_q;
							below_tolerance <= 1'b0;
							scale <= hit ? t : q_q;
							saturated <= sat_q;
							st_q <= ST_IDLE;
						end
					end else begin
						bit_q <= bit_q - 5'd1;
						st_q <= ST_SQ;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/column_scaling_factors.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_scaling_factors: reciprocal column norms of a streamed sparse matrix
// Accumulates squares per column; a bit-serial unit computes 1/sqrt(sum).
// ----------------------------------------------------------------------------
// channel | handshake          | payload
// in      | in_valid/in_stall  | value, has_value, last_in_column
// out     | out_valid/out_stall| column_index, scale, below_tolerance, saturated
// cfg     | cfg_valid/cfg_ready| cfg_data (norm_tol_sq)
// Items enter one per cycle while in_stall is low; a below-tolerance or clipped
// column's result is registered as soon as the root unit takes its record, else
// the unit runs square, four partial products and decide for each of 32 bits.
// A four-record queue lets the front keep accepting while roots run; once it
// is full and another record waits, the input stalls. A stalled result holds
// the root unit. Reset is asynchronous; the tolerance resets to 1.
module column_scaling_factors (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	input  logic               has_value,
	input  logic               last_in_column,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [11:0]        column_index,
	output logic [31:0]        scale,
	output logic               below_tolerance,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [63:0]        cfg_data
);
	logic [63:0] tol_q;
	logic f_valid, f_stall, q_valid, q_take;
	csf_pkg::col_rec_t f_rec, q_rec;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= csf_pkg::TolReset;
		else if (cfg_valid) tol_q <= cfg_data;
	end

	csf_front u_front (.clk, .arst_n, .in_valid, .value, .has_value, .last_in_column,
		.tol(tol_q), .in_stall, .rec_valid(f_valid), .rec(f_rec), .rec_stall(f_stall));
	csf_fifo u_fifo (.clk, .arst_n, .wr_valid(f_valid), .wr_data(f_rec), .wr_stall(f_stall),
		.rd_valid(q_valid), .rd_data(q_rec), .rd_take(q_take));
	csf_rsqrt u_rsqrt (.clk, .arst_n, .rec_valid(q_valid), .rec(q_rec), .rec_take(q_take),
		.out_valid, .out_stall, .column_index, .scale, .below_tolerance, .saturated);
endmodule
